// ===== src/i2cms_pkg.sv =====
package i2cms_pkg;

   localparam int BITS_PER_BYTE = 8;

   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_STOP  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_SACK  = 3'd4;
   localparam logic [2:0] OP_RACK  = 3'd5;

   localparam logic [2:0] ACT_SDA0     = 3'd0;
   localparam logic [2:0] ACT_SDA1     = 3'd1;
   localparam logic [2:0] ACT_SDA_ACK  = 3'd2;
   localparam logic [2:0] ACT_SDA_BIT  = 3'd3;
   localparam logic [2:0] ACT_SCL1     = 3'd4;
   localparam logic [2:0] ACT_SCL0     = 3'd5;
   localparam logic [2:0] ACT_READ_ACK = 3'd6;
   localparam logic [2:0] ACT_READ_BIT = 3'd7;

   localparam logic [15:0] HALF_RESET = 16'd5;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       ack_bit;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
   } rsp_type;

   function automatic logic [4:0] op_length(input logic [2:0] op);
      logic [4:0] len;
      case (op)
         OP_START: len = 5'd4;
         OP_STOP:  len = 5'd3;
         OP_WRITE: len = 5'(3 * BITS_PER_BYTE);
         OP_READ:  len = 5'(1 + 3 * BITS_PER_BYTE);
         OP_SACK:  len = 5'd3;
         default:  len = 5'd4;
      endcase
      return len;
   endfunction

   // sub is the position within a three-phase bit slot
   function automatic logic [2:0] phase_act(input logic [2:0] op, input logic [4:0] phase,
                                            input logic [1:0] sub);
      logic [2:0] act;
      case (op)
         OP_START: begin
            case (phase[1:0])
               2'd0:    act = ACT_SDA1;
               2'd1:    act = ACT_SCL1;
               2'd2:    act = ACT_SDA0;
               default: act = ACT_SCL0;
            endcase
         end
         OP_STOP: begin
            case (sub)
               2'd0:    act = ACT_SDA0;
               2'd1:    act = ACT_SCL1;
               default: act = ACT_SDA1;
            endcase
         end
         OP_WRITE: begin
            case (sub)
               2'd0:    act = ACT_SDA_BIT;
               2'd1:    act = ACT_SCL1;
               default: act = ACT_SCL0;
            endcase
         end
         OP_READ: begin
            if (phase == 5'd0) begin
               act = ACT_SDA1;
            end else begin
               case (sub)
                  2'd0:    act = ACT_SCL1;
                  2'd1:    act = ACT_READ_BIT;
                  default: act = ACT_SCL0;
               endcase
            end
         end
         OP_SACK: begin
            case (sub)
               2'd0:    act = ACT_SDA_ACK;
               2'd1:    act = ACT_SCL1;
               default: act = ACT_SCL0;
            endcase
         end
         default: begin
            case (phase[1:0])
               2'd0:    act = ACT_SDA1;
               2'd1:    act = ACT_SCL1;
               2'd2:    act = ACT_READ_ACK;
               default: act = ACT_SCL0;
            endcase
         end
      endcase
      return act;
   endfunction

endpackage

// ===== src/i2c_master_bit_sequencer_core.sv =====
// Channel   Ports                          Transfer
// req       req_valid/req_ready/req_data   one timebase tick with optional command
// rsp       rsp_valid/rsp_ready/rsp_data   line levels and status after that tick
// csr       csr_we/csr_wdata               half period in ticks, written at once
//
// One tick per clock while req_ready is high; its result is registered in the output or skid register.
// A skid register lets one more tick in while a result waits on rsp_ready.
// req_ready drops only while both output and skid registers hold results.
// Reset is synchronous: lines released, idle, half period 5.
module i2c_master_bit_sequencer_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cms_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cms_pkg::rsp_type  rsp_data,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata
);
   import i2cms_pkg::*;

   logic [15:0] half_ff;
   logic [2:0]  op_ff, op_in;
   logic        run_ff, run_in;
   logic [4:0]  phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [1:0]  sub_ff, sub_in;
   logic [2:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        ack_ff, ack_in;
   logic [7:0]  tx_ff, tx_in;
   logic        ackl_ff, ackl_in;

   logic [15:0] hold;
   logic [4:0]  phase_nx;
   logic        apply;
   logic        done;
   logic [2:0]  act;
   logic        accept;
   rsp_type     result;

   rsp_type     out_ff, skid_ff;
   logic        out_v_ff, skid_v_ff;

   assign hold   = (half_ff == 16'd0) ? 16'd1 : half_ff;
   assign accept = req_valid && req_ready;
   assign phase_nx = phase_ff + 5'd1;

   always_comb begin
      op_in    = op_ff;
      run_in   = run_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      sub_in   = sub_ff;
      bit_in   = bit_ff;
      tx_in    = tx_ff;
      ackl_in  = ackl_ff;
      apply    = 1'b0;
      done     = 1'b0;
      if (run_ff) begin
         if (tick_ff < hold) begin
            tick_in = tick_ff + 16'd1;
         end else begin
            phase_in = phase_nx;
            if (phase_nx >= op_length(op_ff)) begin
               run_in = 1'b0;
               done   = 1'b1;
            end else begin
               apply   = 1'b1;
               tick_in = 16'd1;
               if (op_ff == OP_READ && phase_ff == 5'd0) begin
                  sub_in = 2'd0;
               end else if (sub_ff == 2'd2) begin
                  sub_in = 2'd0;
                  bit_in = bit_ff + 3'd1;
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         end
      end else if (req_data.cmd_valid && req_data.func <= OP_RACK) begin
         op_in    = req_data.func;
         run_in   = 1'b1;
         phase_in = 5'd0;
         sub_in   = 2'd0;
         bit_in   = 3'd0;
         tick_in  = 16'd1;
         apply    = 1'b1;
         if (req_data.func == OP_WRITE) begin
            tx_in = req_data.tx_byte;
         end
         if (req_data.func == OP_SACK) begin
            ackl_in = req_data.ack_bit;
         end
      end
   end

   assign act = phase_act(op_in, phase_in, sub_in);

   always_comb begin
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      shift_in = shift_ff;
      if (apply) begin
         case (act)
            ACT_SDA0:     sda_in = 1'b0;
            ACT_SDA1:     sda_in = 1'b1;
            ACT_SDA_ACK:  sda_in = ackl_in;
            ACT_SDA_BIT:  sda_in = tx_in[3'd7 - bit_in];
            ACT_SCL1:     scl_in = 1'b1;
            ACT_SCL0:     scl_in = 1'b0;
            ACT_READ_ACK: ack_in = req_data.sda_in;
            default:      shift_in = {shift_ff[6:0], req_data.sda_in};
         endcase
      end
   end

   always_comb begin
      result.scl_level = scl_in;
      result.sda_level = sda_in;
      result.busy_res  = run_in;
      result.done_res  = done;
      result.rx_byte   = shift_in;
      result.ack_seen  = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
      end else if (csr_we) begin
         half_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_START;
         run_ff   <= 1'b0;
         phase_ff <= 5'd0;
         tick_ff  <= 16'd0;
         sub_ff   <= 2'd0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         tx_ff    <= 8'd0;
         ackl_ff  <= 1'b0;
      end else if (accept) begin
         op_ff    <= op_in;
         run_ff   <= run_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         sub_ff   <= sub_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
         tx_ff    <= tx_in;
         ackl_ff  <= ackl_in;
      end
   end

   assign req_ready = !skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_v_ff && !rsp_ready) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_ready) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_v_ff && !rsp_ready) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== src/i2cms_checker.sv =====
module i2cms_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input i2cms_pkg::rsp_type  rsp_data,
   input logic                rsp_valid,
   input logic                rsp_ready
);
   import i2cms_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.done_res && rsp_data.busy_res))
      else $error("done and busy together");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("transfer gave no rsp");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

// ===== tb/i2c_master_bit_sequencer_core_tb.sv =====
module i2c_master_bit_sequencer_core_tb;
   import i2cms_pkg::*;

   localparam logic [2:0] OP_BAD6 = 3'd6;
   localparam logic [2:0] OP_BAD7 = 3'd7;

   localparam logic [1:0] SDA_LOW  = 2'd0;
   localparam logic [1:0] SDA_HIGH = 2'd1;
   localparam logic [1:0] SDA_RAND = 2'd2;

   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_OFF   = 150;

   localparam rsp_type IDLE_LINES = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b0,
                                      done_res: 1'b0, rx_byte: 8'h00, ack_seen: 1'b0};
   localparam rsp_type START_LINES = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b1,
                                       done_res: 1'b0, rx_byte: 8'h00, ack_seen: 1'b0};

   typedef enum {RX_OPEN, RX_MOSTLY, RX_TOGGLE, RX_SPARSE} rx_mode_type;

   typedef struct packed {
      logic       cmd;
      logic [2:0] op;
      logic [7:0] data;
      logic       ack;
      logic [1:0] line;
      logic       drain;
      logic       typed;
      rsp_type    exp;
   } dir_row_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [15:0] csr_wdata = '0;

   // line sequencer state as seen by the checker
   logic [15:0] half_ticks = HALF_RESET;
   logic [2:0]  seq_op     = OP_START;
   logic        seq_busy   = 1'b0;
   logic [4:0]  seq_phase  = '0;
   logic [15:0] seq_ticks  = '0;
   logic [7:0]  rx_shift   = '0;
   logic        scl_q      = 1'b1;
   logic        sda_q      = 1'b1;
   logic        ack_q      = 1'b0;
   logic [7:0]  wr_byte    = '0;
   logic        ack_lvl    = 1'b0;

   rsp_type     line_state_q[$];
   logic [2:0]  plan_q[$];
   int          error_count = 0;
   int          burst_left  = 0;

   dir_row_type dir_rows [0:17] = '{
      '{1'b0, OP_START, 8'h00, 1'b0, SDA_HIGH, 1'b0, 1'b1, IDLE_LINES},
      '{1'b1, OP_BAD6,  8'hFF, 1'b1, SDA_LOW,  1'b0, 1'b1, IDLE_LINES},
      '{1'b1, OP_BAD7,  8'h00, 1'b0, SDA_HIGH, 1'b0, 1'b1, IDLE_LINES},
      '{1'b1, OP_START, 8'h00, 1'b0, SDA_RAND, 1'b1, 1'b1, START_LINES},
      '{1'b1, OP_WRITE, 8'hFF, 1'b0, SDA_RAND, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_WRITE, 8'h00, 1'b1, SDA_RAND, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_RACK,  8'h00, 1'b0, SDA_LOW,  1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_RACK,  8'h00, 1'b0, SDA_HIGH, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_READ,  8'h00, 1'b0, SDA_HIGH, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_READ,  8'h00, 1'b0, SDA_LOW,  1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_READ,  8'h00, 1'b0, SDA_RAND, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_SACK,  8'h00, 1'b0, SDA_RAND, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_SACK,  8'h00, 1'b1, SDA_RAND, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0, 1'b0, IDLE_LINES},
      '{1'b1, OP_WRITE, 8'h3C, 1'b1, SDA_RAND, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_STOP,  8'h00, 1'b0, SDA_RAND, 1'b1, 1'b0, IDLE_LINES},
      '{1'b1, OP_STOP,  8'hFF, 1'b1, SDA_RAND, 1'b1, 1'b0, IDLE_LINES}
   };

   i2c_master_bit_sequencer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [4:0] phase_count(input logic [2:0] op);
      case (op)
         OP_START: return 5'd4;
         OP_STOP:  return 5'd3;
         OP_WRITE: return 5'(3 * BITS_PER_BYTE);
         OP_READ:  return 5'(3 * BITS_PER_BYTE + 1);
         OP_SACK:  return 5'd3;
         default:  return 5'd4;
      endcase
   endfunction

   function automatic logic [2:0] line_action(input logic [2:0] op, input logic [4:0] ph);
      logic [2:0] act;
      int slot;
      slot = int'(ph) % 3;
      case (op)
         OP_START: begin
            case (ph[1:0])
               2'd0:    act = ACT_SDA1;
               2'd1:    act = ACT_SCL1;
               2'd2:    act = ACT_SDA0;
               default: act = ACT_SCL0;
            endcase
         end
         OP_STOP:  act = (slot == 0) ? ACT_SDA0 : (slot == 1) ? ACT_SCL1 : ACT_SDA1;
         OP_WRITE: act = (slot == 0) ? ACT_SDA_BIT : (slot == 1) ? ACT_SCL1 : ACT_SCL0;
         OP_READ: begin
            slot = (int'(ph) + 2) % 3;
            if (ph == 5'd0) begin
               act = ACT_SDA1;
            end else begin
               act = (slot == 0) ? ACT_SCL1 : (slot == 1) ? ACT_READ_BIT : ACT_SCL0;
            end
         end
         OP_SACK:  act = (slot == 0) ? ACT_SDA_ACK : (slot == 1) ? ACT_SCL1 : ACT_SCL0;
         default: begin
            case (ph[1:0])
               2'd0:    act = ACT_SDA1;
               2'd1:    act = ACT_SCL1;
               2'd2:    act = ACT_READ_ACK;
               default: act = ACT_SCL0;
            endcase
         end
      endcase
      return act;
   endfunction

   function automatic void apply_action(input logic sda_in);
      logic [2:0] bit_no;
      bit_no = 3'(seq_phase / 5'd3);
      case (line_action(seq_op, seq_phase))
         ACT_SDA0:     sda_q = 1'b0;
         ACT_SDA1:     sda_q = 1'b1;
         ACT_SDA_ACK:  sda_q = ack_lvl;
         ACT_SDA_BIT:  sda_q = wr_byte[3'd7 - bit_no];
         ACT_SCL1:     scl_q = 1'b1;
         ACT_SCL0:     scl_q = 1'b0;
         ACT_READ_ACK: ack_q = sda_in;
         default:      rx_shift = {rx_shift[6:0], sda_in};
      endcase
   endfunction

   function automatic rsp_type seq_tick(input req_type t);
      logic [15:0] hold;
      logic        done;
      rsp_type     r;
      hold = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
      done = 1'b0;
      if (seq_busy) begin
         if (seq_ticks < hold) begin
            seq_ticks++;
         end else begin
            seq_phase++;
            if (seq_phase >= phase_count(seq_op)) begin
               seq_busy = 1'b0;
               done = 1'b1;
            end else begin
               apply_action(t.sda_in);
               seq_ticks = 16'd1;
            end
         end
      end else if (t.cmd_valid && t.func <= OP_RACK) begin
         seq_op = t.func;
         seq_busy = 1'b1;
         seq_phase = '0;
         if (t.func == OP_WRITE) wr_byte = t.tx_byte;
         if (t.func == OP_SACK) ack_lvl = t.ack_bit;
         apply_action(t.sda_in);
         seq_ticks = 16'd1;
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.busy_res  = seq_busy;
      r.done_res  = done;
      r.rx_byte   = rx_shift;
      r.ack_seen  = ack_q;
      return r;
   endfunction

   // mostly well-formed transactions, with some noise commands
   function automatic req_type rand_tick();
      req_type t;
      int      n;
      t.cmd_valid = 1'b0;
      t.func      = 3'($urandom_range(0, 7));
      t.tx_byte   = 8'($urandom_range(0, 255));
      t.ack_bit   = 1'($urandom_range(0, 1));
      t.sda_in    = 1'($urandom_range(0, 1));
      if (!seq_busy && $urandom_range(0, 3) != 0) begin
         t.cmd_valid = 1'b1;
         if ($urandom_range(0, 6) != 0) begin
            if (plan_q.size() == 0) begin
               plan_q.push_back(OP_START);
               plan_q.push_back(OP_WRITE);
               plan_q.push_back(OP_RACK);
               n = $urandom_range(0, 3);
               repeat (n) begin
                  if ($urandom_range(0, 1) == 0) begin
                     plan_q.push_back(OP_WRITE);
                     plan_q.push_back(OP_RACK);
                  end else begin
                     plan_q.push_back(OP_READ);
                     plan_q.push_back(OP_SACK);
                  end
               end
               plan_q.push_back(OP_STOP);
            end
            t.func = plan_q.pop_front();
         end
      end else if (seq_busy && $urandom_range(0, 4) == 0) begin
         t.cmd_valid = 1'b1;
      end
      return t;
   endfunction

   task automatic offer_tick(input req_type t, input logic typed, input rsp_type typed_exp);
      rsp_type pred;
      int      gap;
      pred = seq_tick(t);
      line_state_q.push_back(typed ? typed_exp : pred);
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   // plain ticks until the current command has run out
   task automatic settle_bus(input logic [1:0] line);
      req_type t;
      while (seq_busy) begin
         t = rand_tick();
         t.cmd_valid = 1'b0;
         t.sda_in = (line == SDA_RAND) ? 1'($urandom_range(0, 1)) : line[0];
         offer_tick(t, 1'b0, '0);
      end
   endtask

   task automatic write_half(input logic [15:0] value);
      req_valid <= 1'b0;
      while (line_state_q.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      half_ticks = value;
   endtask

   function automatic void cmp_field(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   initial begin
      dir_row_type row;
      req_type     t;
      logic [15:0] phase_half [5];
      int          phase_items [5];
      phase_half  = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd1};
      phase_items = '{250, 150, 180, 120, 150};
      phase_half[3] = 16'($urandom_range(3, 9));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 18; i++) begin
         row = dir_rows[i];
         t.cmd_valid = row.cmd;
         t.func      = row.op;
         t.tx_byte   = row.data;
         t.ack_bit   = row.ack;
         t.sda_in    = (row.line == SDA_RAND) ? 1'($urandom_range(0, 1)) : row.line[0];
         offer_tick(t, row.typed, row.exp);
         if (row.drain) settle_bus(row.line);
         // shorter hold for the rest of the table
         if (i == 3) write_half(16'd2);
      end

      for (int p = 0; p < 5; p++) begin
         settle_bus(SDA_RAND);
         write_half(phase_half[p]);
         repeat (phase_items[p]) offer_tick(rand_tick(), 1'b0, '0);
      end

      // longest hold: start a command and leave it running
      settle_bus(SDA_RAND);
      write_half(16'hFFFF);
      t = rand_tick();
      t.cmd_valid = 1'b1;
      t.func = OP_START;
      offer_tick(t, 1'b0, '0);
      repeat (40) offer_tick(rand_tick(), 1'b0, '0);

      req_valid <= 1'b0;
      while (line_state_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      rx_mode_type mode;
      int          len;
      while (reset) @(posedge clock);
      repeat (30) begin
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
      // long hold-off while ticks keep coming
      rsp_ready <= 1'b0;
      repeat (HOLD_OFF) @(posedge clock);
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         len  = $urandom_range(10, 200);
         repeat (len) begin
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_MOSTLY: rsp_ready <= ($urandom_range(0, 9) < 7);
               RX_TOGGLE: rsp_ready <= ~rsp_ready;
               default:   rsp_ready <= ($urandom_range(0, 9) < 3);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (line_state_q.size() == 0) begin
               $error("rsp transfer with no expected line state");
               error_count++;
            end else begin
               want = line_state_q.pop_front();
               cmp_field("scl_level", 8'(want.scl_level), 8'(rsp_data.scl_level));
               cmp_field("sda_level", 8'(want.sda_level), 8'(rsp_data.sda_level));
               cmp_field("busy_res", 8'(want.busy_res), 8'(rsp_data.busy_res));
               cmp_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
               cmp_field("rx_byte", want.rx_byte, rsp_data.rx_byte);
               cmp_field("ack_seen", 8'(want.ack_seen), 8'(rsp_data.ack_seen));
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule
